// ----- rtl/tce_pkg.sv -----
// shared types, character codes and sizes for the terminal escape engine
package tce_pkg;

   // longest escape sequence in bytes taken after ESC
   localparam int ESCAPE_MAX = 16;
   localparam int ESC_LEN_W  = $clog2(ESCAPE_MAX + 1);

   // result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // geometry after reset
   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET = 8'd25;

   // character codes
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_B        = 8'h42;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_J        = 8'h4A;
   localparam logic [7:0] CH_M        = 8'h4D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_R        = 8'h72;

   typedef enum logic [1:0] {
      ACT_PLOT   = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_FLUSH  = 2'd2,
      ACT_SCROLL = 2'd3
   } action_type;

   typedef enum logic {
      CSR_TEXT_COLUMNS = 1'b0,
      CSR_TEXT_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  glyph_in;
      logic [31:0] colour;
   } req_word_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  glyph_out;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [31:0] plot_colour;
      logic        raw_mode;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]           cursor_col;
      logic [7:0]           cursor_row;
      logic                 in_escape;
      logic [ESC_LEN_W-1:0] escape_length;
      logic [7:0]           escape_lead;
      logic [7:0]           escape_number;
      logic                 mode_raw;
   } term_state_type;

   // up to two result words made by one character
   typedef struct packed {
      rsp_word_type word0;
      rsp_word_type word1;
      logic [1:0]   count;
   } step_result_type;

endpackage

// ----- rtl/tce_step.sv -----
// one character through cursor, mode and escape parser logic
module tce_step (
   input  tce_pkg::term_state_type  state_cur,
   input  tce_pkg::req_word_type    req_word,
   input  logic [7:0]               text_columns,
   input  logic [7:0]               text_rows,
   output tce_pkg::term_state_type  state_nxt,
   output tce_pkg::step_result_type result
);
   import tce_pkg::*;

   logic [7:0]           cols;
   logic [7:0]           rows;
   logic [7:0]           cols_m1;
   logic [7:0]           rows_m1;
   logic [7:0]           glyph;
   logic [7:0]           row_adj;
   logic [7:0]           num;
   logic [ESC_LEN_W-1:0] esc_pos;
   logic [11:0]          num_sum;
   logic [8:0]           sum9;
   logic [8:0]           col_inc;
   logic                 scroll;
   logic                 stop;
   logic                 have_main;
   rsp_word_type         scroll_word;
   rsp_word_type         main_word;

   // zero geometry acts as one
   assign cols    = (text_columns == 8'd0) ? 8'd1 : text_columns;
   assign rows    = (text_rows == 8'd0) ? 8'd1 : text_rows;
   assign cols_m1 = cols - 8'd1;
   assign rows_m1 = rows - 8'd1;
   assign glyph   = req_word.glyph_in;
   assign num     = state_cur.escape_number;
   assign esc_pos = state_cur.escape_length;

   always_comb begin
      state_nxt   = state_cur;
      scroll      = 1'b0;
      have_main   = 1'b0;
      stop        = 1'b0;
      row_adj     = state_cur.cursor_row;
      num_sum     = '0;
      sum9        = '0;
      col_inc     = '0;
      scroll_word = '0;
      main_word   = '0;
      scroll_word.action   = ACT_SCROLL;
      scroll_word.raw_mode = state_cur.mode_raw;
      main_word.raw_mode   = state_cur.mode_raw;

      if (state_cur.in_escape) begin
         // escape parser: one byte of the sequence
         state_nxt.escape_length = esc_pos + ESC_LEN_W'(1);
         if (esc_pos == '0) begin
            state_nxt.escape_lead = glyph;
            if (glyph != CH_M && glyph != CH_LBRACKET) begin
               stop = 1'b1;
            end
         end else if (state_cur.escape_lead == CH_M) begin
            state_nxt.mode_raw = (glyph == CH_R);
            stop = 1'b1;
         end else if (esc_pos == ESC_LEN_W'(1) && glyph == CH_H) begin
            state_nxt.cursor_col = 8'd0;
            state_nxt.cursor_row = 8'd0;
            stop = 1'b1;
         end else if (glyph >= CH_ZERO && glyph <= CH_NINE) begin
            // decimal argument, saturating
            num_sum = ({4'd0, num} << 3) + ({4'd0, num} << 1) + {4'd0, glyph - CH_ZERO};
            state_nxt.escape_number = (num_sum > 12'd255) ? 8'd255 : num_sum[7:0];
         end else begin
            // final byte of a bracket sequence
            unique case (glyph)
               CH_J: begin
                  if (esc_pos == ESC_LEN_W'(2) && num == 8'd2) begin
                     have_main = 1'b1;
                     main_word.action = ACT_CLEAR;
                  end
               end
               CH_A: begin
                  state_nxt.cursor_row = (state_cur.cursor_row >= num) ?
                                         state_cur.cursor_row - num : 8'd0;
               end
               CH_B: begin
                  sum9 = {1'b0, state_cur.cursor_row} + {1'b0, num};
                  state_nxt.cursor_row = (sum9 > {1'b0, rows_m1}) ? rows_m1 : sum9[7:0];
               end
               CH_C: begin
                  sum9 = {1'b0, state_cur.cursor_col} + {1'b0, num};
                  state_nxt.cursor_col = (sum9 > {1'b0, cols_m1}) ? cols_m1 : sum9[7:0];
               end
               CH_D: begin
                  state_nxt.cursor_col = (state_cur.cursor_col >= num) ?
                                         state_cur.cursor_col - num : 8'd0;
               end
               default: begin
               end
            endcase
            stop = 1'b1;
         end
         // overlong sequence ends with no effect
         if (!stop && state_nxt.escape_length >= ESC_LEN_W'(ESCAPE_MAX)) begin
            stop = 1'b1;
         end
         if (stop) begin
            state_nxt.in_escape     = 1'b0;
            state_nxt.escape_length = '0;
            state_nxt.escape_lead   = 8'd0;
            state_nxt.escape_number = 8'd0;
         end
      end else begin
         // cursor below the screen: one scroll first
         scroll  = (state_cur.cursor_row >= rows);
         row_adj = scroll ? state_cur.cursor_row - 8'd1 : state_cur.cursor_row;
         state_nxt.cursor_row = row_adj;

         unique case (glyph)
            CH_NUL: begin
            end
            CH_LF: begin
               state_nxt.cursor_col = 8'd0;
               state_nxt.cursor_row = (row_adj != 8'hFF) ? row_adj + 8'd1 : row_adj;
               have_main = 1'b1;
               main_word.action = ACT_FLUSH;
            end
            CH_BS: begin
               // backspace wraps to the last column of the row above
               if (state_cur.cursor_col == 8'd0) begin
                  state_nxt.cursor_col = cols_m1;
                  if (row_adj != 8'd0) begin
                     state_nxt.cursor_row = row_adj - 8'd1;
                  end
               end else begin
                  state_nxt.cursor_col = state_cur.cursor_col - 8'd1;
               end
               have_main = 1'b1;
               main_word.action      = ACT_PLOT;
               main_word.glyph_out   = CH_SPACE;
               main_word.cell_col    = state_nxt.cursor_col;
               main_word.cell_row    = state_nxt.cursor_row;
               main_word.plot_colour = req_word.colour;
            end
            CH_ESC: begin
               state_nxt.in_escape     = 1'b1;
               state_nxt.escape_length = '0;
               state_nxt.escape_lead   = 8'd0;
               state_nxt.escape_number = 8'd0;
            end
            default: begin
               // printable: plot then advance with wrap
               have_main = 1'b1;
               main_word.action      = ACT_PLOT;
               main_word.glyph_out   = glyph;
               main_word.cell_col    = state_cur.cursor_col;
               main_word.cell_row    = row_adj;
               main_word.plot_colour = req_word.colour;
               col_inc = {1'b0, state_cur.cursor_col} + 9'd1;
               if (col_inc >= {1'b0, cols}) begin
                  state_nxt.cursor_col = 8'd0;
                  state_nxt.cursor_row = (row_adj != 8'hFF) ? row_adj + 8'd1 : row_adj;
               end else begin
                  state_nxt.cursor_col = col_inc[7:0];
               end
            end
         endcase
      end
   end

   // order the words and mark the final one
   always_comb begin
      result = '0;
      if (scroll) begin
         result.word0      = scroll_word;
         result.word1      = main_word;
         result.word0.last = !have_main;
         result.word1.last = 1'b1;
         result.count      = have_main ? 2'd2 : 2'd1;
      end else begin
         result.word0      = main_word;
         result.word0.last = 1'b1;
         result.count      = have_main ? 2'd1 : 2'd0;
      end
   end

endmodule

// ----- rtl/tce_rsp_fifo.sv -----
// result word queue taking up to two words per cycle and giving one while rsp_stall is low
module tce_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_en,
   input  tce_pkg::step_result_type push_data,
   output logic                     room_two,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tce_pkg::rsp_word_type    rsp_word
);
   import tce_pkg::*;

   rsp_word_type         entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff;
   logic [RSP_CNT_W-1:0] count_in;
   logic [1:0]           push_n;
   logic                 pop;

   assign push_n    = push_en ? push_data.count : 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entries_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   // pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.word0;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push_data.word1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue fill beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2)))
      else $error("words pushed without room for two");

   a_head_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");
`endif

endmodule

// ----- rtl/terminal_char_escape_engine_top.sv -----
// Character terminal engine: cursor, raw/cooked mode and escape parser.
// The req channel takes one word per character: a glyph byte and a colour.
// Each word causes zero, one or two rsp words (scroll first, then plot,
// clear or flush); the last word of a character has its last bit set.
// A character is accepted on a clock edge with req_valid high and req_stall
// low; it is decoded in that cycle and its words are written into the
// result queue at that edge. One character is taken per cycle while
// req_stall is low, and the four-entry result queue gives one word per
// cycle to rsp while rsp_stall is low. req_stall rises only when the queue
// lacks room for two words, so a stalled receiver (rsp_stall high) holds the
// current rsp word steady and soon backs the req side up. The csr port writes
// text_columns (index 0) and text_rows (index 1); csr_ready is always high.
// Writes must be made only while no character is in flight; the block does
// not enforce this. Synchronous reset returns the cursor to the home cell,
// cooked mode, an idle parser, an 80 by 25 screen and an empty queue.
module terminal_char_escape_engine_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tce_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tce_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tce_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_data
);
   import tce_pkg::*;

   term_state_type  state_ff;
   term_state_type  state_in;
   term_state_type  step_state;
   step_result_type step_result;
   logic [7:0]      cols_ff;
   logic [7:0]      cols_in;
   logic [7:0]      rows_ff;
   logic [7:0]      rows_in;
   logic            room_two;
   logic            req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = !room_two;
   assign req_accept = req_valid && !req_stall;

   // geometry registers
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEXT_COLUMNS: cols_in = csr_data;
            CSR_TEXT_ROWS:    rows_in = csr_data;
         endcase
      end
   end

   // per-character decode
   tce_step u_step (
      .state_cur    (state_ff),
      .req_word     (req_word),
      .text_columns (cols_ff),
      .text_rows    (rows_ff),
      .state_nxt    (step_state),
      .result       (step_result)
   );

   assign state_in = req_accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cols_ff  <= COLS_RESET;
         rows_ff  <= ROWS_RESET;
      end else begin
         state_ff <= state_in;
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
      end
   end

   // result words out
   tce_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_accept),
      .push_data (step_result),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_esc_len_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape_length < ESC_LEN_W'(ESCAPE_MAX))
      else $error("escape length reached its limit without ending");

   a_idle_parser_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.in_escape |-> (state_ff.escape_length == '0 &&
                               state_ff.escape_lead == 8'd0 &&
                               state_ff.escape_number == 8'd0))
      else $error("parser fields left over outside a sequence");

   a_scroll_emits: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !state_ff.in_escape &&
       state_ff.cursor_row >= ((rows_ff == 8'd0) ? 8'd1 : rows_ff))
      |-> (step_result.count != 2'd0 && step_result.word0.action == ACT_SCROLL))
      else $error("cursor below screen without a scroll word");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.cursor_col != 8'hFF)
      else $error("cursor column out of range");
`endif

endmodule
